// File: sv/zpc_pkg.sv
// shared constants and types for the zero-padded 2d convolution block
`default_nettype none
package zpc_pkg;

  localparam int MAX_KERNEL = 5;
  localparam int MAX_RAD    = (MAX_KERNEL - 1) / 2;
  localparam int MAX_COLS   = 1024;
  localparam int MAX_ROWS   = 1024;
  localparam int PIXEL_BITS = 16;
  localparam int COEF_BITS  = 12;
  localparam int RING_ROWS  = MAX_KERNEL + 3;

  localparam int RAD_W    = 2;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int DIM_W    = 11;
  localparam int BANK_W   = $clog2(RING_ROWS);
  localparam int KROW_W   = MAX_KERNEL * COEF_BITS;
  localparam int CFG_W    = 60;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W   = PIXEL_BITS + COEF_BITS;
  localparam int RSUM_W   = PROD_W + 3;
  localparam int TSUM_W   = RSUM_W + 3;
  localparam int RES_W    = 32;
  localparam int OUT_W    = 56;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KROW_A = 3'd3;

  // input kinds
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } job_t;

endpackage
`default_nettype wire

// File: sv/zero_padded_2d_convolution_top.sv
// top level of the streaming zero-padded 2d convolution
`default_nettype none
// Streaming 2d convolution with zero padding. Pixels arrive in raster order on the
// slave stream (tuser low = pixel, tuser high = drain tick); each output (row, col,
// exact 32-bit sum) leaves on the master stream, tlast marking the frame's final
// output. A pixel request is taken every clock while the output is not stalled; at the
// first output of each row tready is also low during the window preload, which reads
// kernel_radius extra columns. The request that completes a window passes the fetch,
// line-buffer read, window, product, row-sum and output registers before its output
// leaves, after the preload at a row start. The line buffer is one
// 1024 x 128 memory (one 16-bit lane per ring row, eight rows), written one lane
// per pixel and read one column per cycle; that single read port sets the rate.
// The window slides one column per column read, and 25 parallel multipliers feed a
// registered two-level adder tree. Geometry writes restart the frame; all writes
// must happen while the block is idle. Drain ticks flush outputs after the frame.
module zero_padded_2d_convolution_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [zpc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [zpc_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [zpc_pkg::PIXEL_BITS-1:0]  s_axis_tdata,  // pixel
  input  logic                            s_axis_tuser,  // operation
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [zpc_pkg::OUT_W-1:0]       m_axis_tdata,  // result, out_row, out_col, zero pad
  output logic                            m_axis_tlast   // frame_last
);
  import zpc_pkg::*;

  // configuration
  logic [RAD_W-1:0]  rad_cfg_q;
  logic [DIM_W-1:0]  rows_cfg_q, cols_cfg_q;
  logic [KROW_W-1:0] kern_q [MAX_KERNEL];
  logic [RAD_W-1:0]  rad;
  logic [DIM_W-1:0]  rows_eff, cols_eff;
  logic [2:0]        ksz_m1;
  logic              geom_wr;

  // frame counters
  logic [DIM_W-1:0] in_row_q, in_row_d;
  logic [COL_W-1:0] in_col_q, in_col_d;
  logic [ROW_W-1:0] out_row_q, out_row_d;
  logic [COL_W-1:0] out_col_q, out_col_d;

  // pipeline
  logic en, acc, wr, emit, last;
  logic [DIM_W-1:0] need_r, need_c, in_col_inc, out_col_inc, in_row_n;
  logic [COL_W-1:0] in_col_n;

  logic              f_v_q, f_first_q;
  logic [RAD_W-1:0]  f_cnt_q;
  logic [DIM_W-1:0]  f_col_q;
  job_t              f_job_q;
  logic              f_busy;

  logic [RING_ROWS*PIXEL_BITS-1:0] line_mem [MAX_COLS];
  logic [RING_ROWS*PIXEL_BITS-1:0] rd_q;

  logic d_v_q, d_emit_q, d_clear_q, d_zero_q;
  job_t d_job_q;
  logic signed [PIXEL_BITS-1:0] new_col [MAX_KERNEL];
  logic signed [PIXEL_BITS-1:0] win_q [MAX_KERNEL][MAX_KERNEL];
  logic w_v_q;  job_t w_job_q;
  logic signed [PROD_W-1:0] prod_q [MAX_KERNEL][MAX_KERNEL];
  logic signed [PROD_W-1:0] prod_d [MAX_KERNEL][MAX_KERNEL];
  logic p_v_q;  job_t p_job_q;
  logic signed [RSUM_W-1:0] rs_q [MAX_KERNEL];
  logic signed [RSUM_W-1:0] rs_d [MAX_KERNEL];
  logic s_v_q;  job_t s_job_q;
  logic signed [TSUM_W-1:0] tot_d;
  logic out_v_q; job_t out_job_q;
  logic [RES_W-1:0] out_res_q;

  // effective geometry
  always_comb begin
    rad = (rad_cfg_q > RAD_W'(MAX_RAD)) ? RAD_W'(MAX_RAD) : rad_cfg_q;
    ksz_m1 = {rad, 1'b0};
    rows_eff = (rows_cfg_q == '0) ? DIM_W'(1) :
               (rows_cfg_q > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : rows_cfg_q;
    cols_eff = (cols_cfg_q == '0) ? DIM_W'(1) :
               (cols_cfg_q > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cols_cfg_q;
    geom_wr = cfg_we_i && (cfg_index_i == CFG_RADIUS || cfg_index_i == CFG_ROWS ||
                           cfg_index_i == CFG_COLS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_cfg_q  <= RAD_W'(1);
      rows_cfg_q <= DIM_W'(5);
      cols_cfg_q <= DIM_W'(5);
      for (int k = 0; k < MAX_KERNEL; k++) kern_q[k] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_RADIUS: rad_cfg_q  <= cfg_data_i[RAD_W-1:0];
        CFG_ROWS:   rows_cfg_q <= cfg_data_i[DIM_W-1:0];
        CFG_COLS:   cols_cfg_q <= cfg_data_i[DIM_W-1:0];
        default:    kern_q[cfg_index_i - CFG_KROW_A] <= cfg_data_i[KROW_W-1:0];
      endcase
    end
  end

  // global advance: held while a finished output waits
  assign en = !out_v_q || m_axis_tready;
  assign f_busy = f_v_q && (f_cnt_q != '0);
  assign s_axis_tready = en && !f_busy;
  assign acc = s_axis_tvalid && s_axis_tready;

  // input position and output decision, in request order
  always_comb begin
    wr = acc && (s_axis_tuser == OP_PIXEL) && (in_row_q < rows_eff);
    in_col_inc = {1'b0, in_col_q} + DIM_W'(1);
    in_row_n = in_row_q;
    in_col_n = in_col_q;
    if (wr) begin
      if (in_col_inc >= cols_eff) begin
        in_col_n = '0;
        in_row_n = in_row_q + DIM_W'(1);
      end else begin
        in_col_n = in_col_inc[COL_W-1:0];
      end
    end
    need_r = {1'b0, out_row_q} + DIM_W'(rad);
    if (need_r > rows_eff - DIM_W'(1)) need_r = rows_eff - DIM_W'(1);
    need_c = {1'b0, out_col_q} + DIM_W'(rad);
    if (need_c > cols_eff - DIM_W'(1)) need_c = cols_eff - DIM_W'(1);
    // window complete when its last pixel lies before the input position
    emit = acc && ({1'b0, out_row_q} < rows_eff) &&
           ((need_r < in_row_n) || (need_r == in_row_n && need_c < {1'b0, in_col_n}));
    last = ({1'b0, out_row_q} == rows_eff - DIM_W'(1)) &&
           ({1'b0, out_col_q} == cols_eff - DIM_W'(1));
    out_col_inc = {1'b0, out_col_q} + DIM_W'(1);

    in_row_d = in_row_n;
    in_col_d = in_col_n;
    out_row_d = out_row_q;
    out_col_d = out_col_q;
    if (emit) begin
      if (out_col_inc >= cols_eff) begin
        out_col_d = '0;
        out_row_d = out_row_q + ROW_W'(1);
      end else begin
        out_col_d = out_col_inc[COL_W-1:0];
      end
    end
    if (geom_wr || (emit && last)) begin
      in_row_d = '0;
      in_col_d = '0;
      out_row_d = '0;
      out_col_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
    end else begin
      in_row_q  <= in_row_d;
      in_col_q  <= in_col_d;
      out_row_q <= out_row_d;
      out_col_q <= out_col_d;
    end
  end

  // fetch: one column read per output, radius+1 reads at a row start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q <= 1'b0;
      f_cnt_q <= '0;
      f_first_q <= 1'b0;
    end else if (en) begin
      if (f_busy) begin
        f_cnt_q <= f_cnt_q - RAD_W'(1);
        f_first_q <= 1'b0;
      end else if (emit) begin
        f_v_q <= 1'b1;
        f_cnt_q <= (out_col_q == '0) ? rad : '0;
        f_first_q <= (out_col_q == '0);
      end else begin
        f_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (f_busy) begin
        f_col_q <= f_col_q + DIM_W'(1);
      end else if (emit) begin
        f_col_q <= (out_col_q == '0) ? '0 : ({1'b0, out_col_q} + DIM_W'(rad));
        f_job_q <= '{row: out_row_q, col: out_col_q, last: last};
      end
    end
  end

  // line buffer: lane per ring row
  always_ff @(posedge clk_i) begin
    if (wr) begin
      for (int b = 0; b < RING_ROWS; b++) begin
        if (in_row_q[BANK_W-1:0] == BANK_W'(b))
          line_mem[in_col_q][b*PIXEL_BITS +: PIXEL_BITS] <= s_axis_tdata;
      end
    end
    if (en && f_v_q) rd_q <= line_mem[f_col_q[COL_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_v_q <= 1'b0;
    end else if (en) begin
      d_v_q <= f_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_emit_q  <= (f_cnt_q == '0);
      d_clear_q <= f_first_q;
      d_zero_q  <= (f_col_q >= cols_eff);
      d_job_q   <= f_job_q;
    end
  end

  // arriving column, masked outside the frame
  always_comb begin
    logic signed [DIM_W:0] pr;
    logic [BANK_W-1:0] bank;
    for (int i = 0; i < MAX_KERNEL; i++) begin
      pr = $signed({2'b00, d_job_q.row}) - $signed({{(DIM_W-1){1'b0}}, rad})
           + (DIM_W+1)'(i);
      bank = pr[BANK_W-1:0];
      new_col[i] = '0;
      if (3'(i) <= ksz_m1 && pr >= 0 && pr < $signed({1'b0, rows_eff}) && !d_zero_q)
        new_col[i] = rd_q[bank*PIXEL_BITS +: PIXEL_BITS];
    end
  end

  // window slides one column left per arrival
  always_ff @(posedge clk_i) begin
    if (en && d_v_q) begin
      for (int i = 0; i < MAX_KERNEL; i++) begin
        for (int j = 0; j < MAX_KERNEL; j++) begin
          if (3'(j) == ksz_m1)
            win_q[i][j] <= new_col[i];
          else if (3'(j) > ksz_m1 || d_clear_q || j == MAX_KERNEL - 1)
            win_q[i][j] <= '0;
          else
            win_q[i][j] <= win_q[i][j+1];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_KERNEL; i++) begin
      for (int j = 0; j < MAX_KERNEL; j++)
        prod_d[i][j] = win_q[i][j] *
                       $signed(kern_q[i][j*COEF_BITS +: COEF_BITS]);
    end
    for (int i = 0; i < MAX_KERNEL; i++) begin
      rs_d[i] = '0;
      for (int j = 0; j < MAX_KERNEL; j++)
        rs_d[i] = rs_d[i] + RSUM_W'(prod_q[i][j]);
    end
    tot_d = '0;
    for (int i = 0; i < MAX_KERNEL; i++)
      tot_d = tot_d + TSUM_W'(rs_q[i]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_v_q <= 1'b0;
      p_v_q <= 1'b0;
      s_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      w_v_q <= d_v_q && d_emit_q;
      p_v_q <= w_v_q;
      s_v_q <= p_v_q;
      out_v_q <= s_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      w_job_q <= d_job_q;
      p_job_q <= w_job_q;
      prod_q <= prod_d;
      s_job_q <= p_job_q;
      rs_q <= rs_d;
      out_job_q <= s_job_q;
      out_res_q <= tot_d[RES_W-1:0];
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {(OUT_W-RES_W-ROW_W-COL_W)'(0), out_job_q.col, out_job_q.row,
                          out_res_q};
  assign m_axis_tlast  = out_job_q.last;

endmodule
`default_nettype wire

// File: sv/zpc_checker.sv
// port-level checker for the convolution top level, with its bind
`default_nettype none
module zpc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            cfg_we_i,
  input logic [zpc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input logic [zpc_pkg::CFG_W-1:0]       cfg_data_i,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [zpc_pkg::PIXEL_BITS-1:0]  s_axis_tdata,
  input logic                            s_axis_tuser,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [zpc_pkg::OUT_W-1:0]       m_axis_tdata,
  input logic                            m_axis_tlast
);
  import zpc_pkg::*;

  // a stalled output keeps its request
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("output request changed while stalled");

  // input is held back while an output is stalled
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken during output stall");

  // padding bits of the output stay zero
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OUT_W-1:RES_W+ROW_W+COL_W] == '0)
    else $error("output padding not zero");

  // nothing leaves during reset
  a_rst: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("output valid during reset");

endmodule

bind zero_padded_2d_convolution_top zpc_checker u_zpc_checker (.*);
`default_nettype wire
